// File: sv/ppis_pkg.sv
// Package for the projective plane incidence scan.
// Holds widths, codes, controller states, command/status structs and small helpers.
// No dependencies.
package ppis_pkg;

    localparam int LINE_W   = 6;
    localparam int COORD_W  = 3;
    localparam int SPC_W    = 4;
    localparam int STAT_W   = 2;
    localparam int MAX_ORDER = 7;

    localparam logic [SPC_W-1:0]  SPC_RESET    = 4'd8;
    localparam logic [STAT_W-1:0] STATUS_FOUND = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NONE  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH,
        ST_REJECT
    } state_t;

    // Point families in scan order: (i,j,1), then (i,1,0), then (1,0,0)
    typedef enum logic [1:0] {
        REG_GRID,
        REG_SLOPE,
        REG_INF
    } region_t;

    typedef struct packed {
        logic load;         // capture line and start a scan
        logic advance;      // step to the next point
        logic capture;      // store current point as pending match
        logic emit_mid;     // pending match to output, not last
        logic emit_final;   // pending match (or none status) to output, last
        logic emit_reject;  // range status to output, last
    } cmd_t;

    typedef struct packed {
        logic range_bad;    // offered line index or order is out of range
        logic match;        // current point lies on the line
        logic at_end;       // current point is the last one of the plane
        logic pend_valid;   // a pending match is held
        logic out_free;     // output register can take a result this cycle
    } sts_t;

    // Modular add of two residues already below m
    function automatic logic [COORD_W-1:0] add_mod(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b,
        input logic [COORD_W-1:0] m
    );
        logic [COORD_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= {1'b0, m})
        begin
            sum = sum - {1'b0, m};
        end
        return sum[COORD_W-1:0];
    endfunction

    // Quotient v / q for v < q*q, by counting multiples of q not above v
    function automatic logic [COORD_W-1:0] quot_small(
        input logic [LINE_W-1:0]  v,
        input logic [COORD_W-1:0] q
    );
        logic [COORD_W-1:0] cnt;
        cnt = '0;
        for (int k = 1; k < 8; k++)
        begin
            if (LINE_W'(k) * {3'b000, q} <= v)
            begin
                cnt = cnt + 3'd1;
            end
        end
        return cnt;
    endfunction

endpackage

// File: sv/ppis_line_if.sv
// Request channel interface: one line index per transfer.
// Depends on ppis_pkg.
interface ppis_line_if;
    logic                          valid;
    logic                          ready;
    logic [ppis_pkg::LINE_W-1:0]   line_index;

    modport source (output valid, output line_index, input ready);
    modport sink   (input valid, input line_index, output ready);
endinterface

// File: sv/ppis_point_if.sv
// Result channel interface: one incident point (or status) per transfer.
// Depends on ppis_pkg.
interface ppis_point_if;
    logic                          valid;
    logic                          ready;
    logic [ppis_pkg::LINE_W-1:0]   point_index;
    logic                          last;
    logic [ppis_pkg::STAT_W-1:0]   status;

    modport source (output valid, output point_index, output last, output status,
                    input ready);
    modport sink   (input valid, input point_index, input last, input status,
                    output ready);
endinterface

// File: sv/ppis_cfg_if.sv
// Configuration write channel interface: symbols per card.
// Depends on ppis_pkg.
interface ppis_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ppis_pkg::SPC_W-1:0]    symbols_per_card;

    modport source (output valid, output symbols_per_card, input ready);
    modport sink   (input valid, input symbols_per_card, output ready);
endinterface

// File: sv/projective_plane_incidence_scan.sv
// Incidence scan: one line index in, every incident point of the plane out.
// A new request is taken only from idle, once the previous scan or reject has finished;
// the scan visits one point per cycle through the modular residue adders in the datapath while the output is not held.
// A rejected index goes to the reject state, which writes its range status result to the
// output register once that register is free. Output stalls pause the scan.
// Reset (rst_n, async low) returns to idle, empties the output, sets symbols_per_card to 8.
module projective_plane_incidence_scan
(
    input  logic                clk,
    input  logic                rst_n,
    ppis_cfg_if.sink            cfg,
    ppis_line_if.sink           req,
    ppis_point_if.source        rsp
);

    ppis_pkg::cmd_t cmd;
    ppis_pkg::sts_t sts;

    logic in_ready;

    // Configuration is taken at any time; the user must write it only while idle, not enforced by the block
    assign cfg.ready = 1'b1;

    // Take a request only from idle; the output register keeps a finished
    // result for the sink while the next request is taken
    assign req.ready = in_ready;

    // Controller: sequence load, one point per cycle unless a full output holds the scan, final or reject result
    ppis_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: decode the line, walk the points, hold one pending match so
    // the final one can carry the last flag
    ppis_dpath u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg.valid),
        .cfg_data   (cfg.symbols_per_card),
        .in_line    (req.line_index),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_point  (rsp.point_index),
        .out_last   (rsp.last),
        .out_status (rsp.status)
    );

endmodule

// File: sv/ppis_ctrl.sv
// Scan controller: state machine that sequences load, scan, final result and reject.
// Depends on ppis_pkg.
module ppis_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ppis_pkg::sts_t      sts,
    output ppis_pkg::cmd_t      cmd
);

    ppis_pkg::state_t state_reg;
    ppis_pkg::state_t state_next;

    logic blocked;

    // Hold the scan while a new match needs the output and it is still full
    assign blocked = sts.match && sts.pend_valid && !sts.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppis_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ppis_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.range_bad ? ppis_pkg::ST_REJECT : ppis_pkg::ST_SCAN;
                end
            end
            ppis_pkg::ST_SCAN:
            begin
                if (!blocked && sts.at_end)
                begin
                    state_next = ppis_pkg::ST_FINISH;
                end
            end
            ppis_pkg::ST_FINISH,
            ppis_pkg::ST_REJECT:
            begin
                if (sts.out_free)
                begin
                    state_next = ppis_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppis_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ppis_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid && !sts.range_bad;
            end
            ppis_pkg::ST_SCAN:
            begin
                cmd.advance  = !blocked;
                cmd.capture  = !blocked && sts.match;
                cmd.emit_mid = !blocked && sts.match && sts.pend_valid;
            end
            ppis_pkg::ST_FINISH:
            begin
                cmd.emit_final = sts.out_free;
            end
            ppis_pkg::ST_REJECT:
            begin
                cmd.emit_reject = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: sv/ppis_dpath.sv
// Scan datapath: config register, line coordinates, incremental residue walk,
// pending match and output register. Depends on ppis_pkg.
module ppis_dpath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [ppis_pkg::SPC_W-1:0]      cfg_data,
    input  logic [ppis_pkg::LINE_W-1:0]     in_line,
    input  ppis_pkg::cmd_t                  cmd,
    output ppis_pkg::sts_t                  sts,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ppis_pkg::LINE_W-1:0]     out_point,
    output logic                            out_last,
    output logic [ppis_pkg::STAT_W-1:0]     out_status
);

    localparam int CW = ppis_pkg::COORD_W;
    localparam int LW = ppis_pkg::LINE_W;

    logic [ppis_pkg::SPC_W-1:0] spc_reg;

    logic [CW-1:0]  lx_reg, ly_reg, q_reg, m_reg;
    logic [CW-1:0]  i_reg, j_reg, r_reg, rrow_reg;
    logic [LW-1:0]  n_reg, pend_reg;
    ppis_pkg::region_t region_reg;
    logic           pend_valid_reg;
    logic           out_valid_reg, out_last_reg;
    logic [LW-1:0]  out_point_reg;
    logic [ppis_pkg::STAT_W-1:0] out_status_reg;

    logic [CW-1:0]  i_next, j_next, r_next, rrow_next;
    ppis_pkg::region_t region_next;

    // Offered line decode
    logic [ppis_pkg::SPC_W-1:0] q_wide;
    logic [CW-1:0]  q_c, m_c, lx_c, ly_c, lz_c, quot_c;
    logic [6:0]     qq_c, s_c;
    logic           order_bad;
    logic           out_free;

    assign q_wide    = spc_reg - 4'd1;
    assign q_c       = q_wide[CW-1:0];
    assign order_bad = (spc_reg < 4'd2) || (spc_reg > 4'(ppis_pkg::MAX_ORDER + 1));
    assign qq_c      = 7'({4'b0000, q_c} * {4'b0000, q_c});
    assign s_c       = qq_c + {4'b0000, q_c} + 7'd1;
    assign m_c       = (q_c == 3'd1) ? 3'd2 : q_c;
    assign quot_c    = ppis_pkg::quot_small(in_line, q_c);

    always_comb
    begin
        logic [LW-1:0] prod;
        logic [LW-1:0] rem;
        prod = LW'({3'b000, quot_c} * {3'b000, q_c});
        rem  = in_line - prod;
        if ({1'b0, in_line} < qq_c)
        begin
            lx_c = quot_c;
            ly_c = rem[CW-1:0];
            lz_c = 3'd1;
        end
        else if ({1'b0, in_line} < qq_c + {4'b0000, q_c})
        begin
            rem  = in_line - qq_c[LW-1:0];
            lx_c = rem[CW-1:0];
            ly_c = 3'd1;
            lz_c = 3'd0;
        end
        else
        begin
            lx_c = 3'd1;
            ly_c = 3'd0;
            lz_c = 3'd0;
        end
    end

    // Walk to the next point, keeping the dot product modulo m
    always_comb
    begin
        i_next      = i_reg;
        j_next      = j_reg;
        r_next      = r_reg;
        rrow_next   = rrow_reg;
        region_next = region_reg;
        case (region_reg)
            ppis_pkg::REG_GRID:
            begin
                if (j_reg == q_reg - 3'd1)
                begin
                    j_next = '0;
                    if (i_reg == q_reg - 3'd1)
                    begin
                        i_next      = '0;
                        region_next = ppis_pkg::REG_SLOPE;
                        r_next      = ly_reg;
                    end
                    else
                    begin
                        i_next    = i_reg + 3'd1;
                        rrow_next = ppis_pkg::add_mod(rrow_reg, lx_reg, m_reg);
                        r_next    = rrow_next;
                    end
                end
                else
                begin
                    j_next = j_reg + 3'd1;
                    r_next = ppis_pkg::add_mod(r_reg, ly_reg, m_reg);
                end
            end
            ppis_pkg::REG_SLOPE:
            begin
                if (i_reg == q_reg - 3'd1)
                begin
                    region_next = ppis_pkg::REG_INF;
                    r_next      = lx_reg;
                end
                else
                begin
                    i_next = i_reg + 3'd1;
                    r_next = ppis_pkg::add_mod(r_reg, lx_reg, m_reg);
                end
            end
            default:
            begin
                region_next = region_reg;
            end
        endcase
    end

    assign out_free       = !out_valid_reg || out_ready;
    assign sts.range_bad  = order_bad || ({1'b0, in_line} >= s_c);
    assign sts.match      = (r_reg == '0);
    assign sts.at_end     = (region_reg == ppis_pkg::REG_INF);
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spc_reg        <= ppis_pkg::SPC_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                spc_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.capture)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (cmd.emit_mid || cmd.emit_final || cmd.emit_reject)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lx_reg     <= lx_c;
            ly_reg     <= ly_c;
            q_reg      <= q_c;
            m_reg      <= m_c;
            n_reg      <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            region_reg <= ppis_pkg::REG_GRID;
            r_reg      <= lz_c;
            rrow_reg   <= lz_c;
        end
        else if (cmd.advance)
        begin
            n_reg      <= n_reg + 6'd1;
            i_reg      <= i_next;
            j_reg      <= j_next;
            region_reg <= region_next;
            r_reg      <= r_next;
            rrow_reg   <= rrow_next;
        end
        if (cmd.capture)
        begin
            pend_reg <= n_reg;
        end
        if (cmd.emit_mid)
        begin
            out_point_reg  <= pend_reg;
            out_last_reg   <= 1'b0;
            out_status_reg <= ppis_pkg::STATUS_FOUND;
        end
        else if (cmd.emit_final)
        begin
            out_point_reg  <= pend_valid_reg ? pend_reg : '0;
            out_last_reg   <= 1'b1;
            out_status_reg <= pend_valid_reg ? ppis_pkg::STATUS_FOUND : ppis_pkg::STATUS_NONE;
        end
        else if (cmd.emit_reject)
        begin
            out_point_reg  <= '0;
            out_last_reg   <= 1'b1;
            out_status_reg <= ppis_pkg::STATUS_RANGE;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_point  = out_point_reg;
    assign out_last   = out_last_reg;
    assign out_status = out_status_reg;

`ifndef SYNTHESIS
    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_mid || cmd.emit_final || cmd.emit_reject) |-> out_free)
        else $error("result written while output register is held");

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_mid, cmd.emit_final, cmd.emit_reject}))
        else $error("more than one result written in a cycle");

    a_capture_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (r_reg == '0))
        else $error("pending point captured without a zero residue");

    a_final_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_final || cmd.emit_reject) |=> (out_valid_reg && out_last_reg))
        else $error("closing result not marked last");
`endif

endmodule

// File: test/tb_top.sv
// Self-checking testbench for projective_plane_incidence_scan: directed and random line requests
// under random sender bursts and receiver stalls, checked against an in-bench incidence predictor.
// Depends on ppis_pkg and the ppis_cfg_if, ppis_line_if and ppis_point_if interfaces.
`timescale 1ns / 100ps

module tb_top;

    localparam int LW = ppis_pkg::LINE_W;
    localparam int SW = ppis_pkg::SPC_W;

    // One result transfer as the block should present it
    typedef struct packed {
        logic [ppis_pkg::LINE_W-1:0] point_index;
        logic                        last;
        logic [ppis_pkg::STAT_W-1:0] status;
    } incidence_t;

    logic clk;
    logic rst_n;

    ppis_cfg_if   cfg_bus ();
    ppis_line_if  req_bus ();
    ppis_point_if rsp_bus ();

    projective_plane_incidence_scan DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Predictor state: the register copy
    logic [ppis_pkg::SPC_W-1:0] plane_spc;

    // Incident points still owed by the block, oldest first
    incidence_t expected_incidences[$];

    int  fail_count;
    logic sink_free;    // receiver takes every result when high

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Homogeneous triple of index n in a plane of order q
    function automatic void plane_triple(input int n, input int q,
                                         output int x, output int y, output int z);
        if (n < q * q)
        begin
            x = n / q;
            y = n % q;
            z = 1;
        end
        else if (n < q * q + q)
        begin
            x = n - q * q;
            y = 1;
            z = 0;
        end
        else
        begin
            x = 1;
            y = 0;
            z = 0;
        end
    endfunction

    // Append one owed result at the tail of the queue
    task automatic owe_result(input incidence_t r);
        expected_incidences.insert(expected_incidences.size(), r);
    endtask

    // Queue every result one accepted line index must produce
    task automatic predict_incidences(input logic [ppis_pkg::LINE_W-1:0] line);
        int q;
        int span;
        int modulus;
        int lx, ly, lz;
        int px, py, pz;
        int hits;
        incidence_t r;
        q = int'(plane_spc) - 1;
        span = q * q + q + 1;
        if (plane_spc < 2 || plane_spc > ppis_pkg::MAX_ORDER + 1 || int'(line) >= span)
        begin
            // Bad order or index past the plane: one range status
            r.point_index = '0;
            r.last = 1'b1;
            r.status = ppis_pkg::STATUS_RANGE;
            owe_result(r);
        end
        else
        begin
            modulus = (q == 1) ? 2 : q;
            plane_triple(int'(line), q, lx, ly, lz);
            hits = 0;
            for (int n = 0; n < span; n++)
            begin
                plane_triple(n, q, px, py, pz);
                if ((lx * px + ly * py + lz * pz) % modulus == 0)
                begin
                    r.point_index = n[LW-1:0];
                    r.last = 1'b0;
                    r.status = ppis_pkg::STATUS_FOUND;
                    owe_result(r);
                    hits++;
                end
            end
            if (hits == 0)
            begin
                r.point_index = '0;
                r.last = 1'b1;
                r.status = ppis_pkg::STATUS_NONE;
                owe_result(r);
            end
            else
            begin
                // Flag the final incident point of this line
                expected_incidences[expected_incidences.size() - 1].last = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare each transfer with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_incidence
        incidence_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_incidences.size() == 0)
            begin
                $error("unexpected result transfer: point_index %0d last %0d status %0d",
                       rsp_bus.point_index, rsp_bus.last, rsp_bus.status);
                fail_count++;
            end
            else
            begin
                want = expected_incidences.pop_front();
                if (rsp_bus.point_index !== want.point_index)
                begin
                    $error("point_index mismatch: expected %0d, actual %0d",
                           want.point_index, rsp_bus.point_index);
                    fail_count++;
                end
                if (rsp_bus.last !== want.last)
                begin
                    $error("last mismatch: expected %0d, actual %0d",
                           want.last, rsp_bus.last);
                    fail_count++;
                end
                if (rsp_bus.status !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, rsp_bus.status);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: rotate a random stall mask, swap it when its random lifetime runs out.
    // A bit forced set in every mask bounds the length of a stall.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        logic [15:0] stall_mask;
        int          mask_life;
        stall_mask = 16'hFFFF;
        mask_life = 0;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mask_life == 0)
            begin
                stall_mask = 16'($urandom()) | 16'h0001;
                if ($urandom_range(0, 3) == 0)
                begin
                    stall_mask = 16'hFFFF;
                end
                mask_life = $urandom_range(20, 80);
            end
            else
            begin
                mask_life--;
            end
            stall_mask = {stall_mask[0], stall_mask[15:1]};
            rsp_bus.ready <= sink_free || stall_mask[0];
        end
    end

    // ------------------------------------------------------------------
    // Shared driving tasks. Each is entered just after a rising edge.
    // ------------------------------------------------------------------

    // Offer one line index and hold it until the transfer; valid stays high
    task automatic send_line(input logic [ppis_pkg::LINE_W-1:0] line);
        req_bus.valid <= 1'b1;
        req_bus.line_index <= line;
        do
            @(posedge clk);
        while (!req_bus.ready);
        predict_incidences(line);
    endtask

    // Drop the request for a gap whose length the caller gives
    task automatic hold_requests(input int cycles);
        req_bus.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop the request and wait out every owed result, then let the block settle
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_incidences.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write symbols_per_card while the block is idle
    task automatic write_symbols(input logic [ppis_pkg::SPC_W-1:0] value);
        drain_results();
        cfg_bus.valid <= 1'b1;
        cfg_bus.symbols_per_card <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        plane_spc = value;
    endtask

    // Mostly indices inside the current plane, some anywhere in the field
    function automatic logic [ppis_pkg::LINE_W-1:0] pick_line();
        int q;
        int span;
        q = int'(plane_spc) - 1;
        span = q * q + q + 1;
        if (plane_spc >= 2 && plane_spc <= ppis_pkg::MAX_ORDER + 1
            && $urandom_range(0, 99) < 85)
        begin
            return LW'($urandom_range(0, span - 1));
        end
        return LW'($urandom_range(0, 63));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Order 7 straight out of reset, no register write yet
    task automatic test_reset_order();
        sink_free <= 1'b1;
        send_line(6'd0);
        send_line(6'd23);
        send_line(6'd49);
        send_line(6'd56);     // line (1,0,0), last index of the plane
        send_line(6'd57);     // first index past the plane
        send_line(6'd63);
        drain_results();
    endtask

    // Order 1 uses the mod-2 rule
    task automatic test_smallest_plane();
        sink_free <= 1'b0;
        write_symbols(4'd2);
        send_line(6'd0);
        send_line(6'd1);
        send_line(6'd2);
        send_line(6'd3);
        send_line(6'd42);
        drain_results();
    endtask

    // Non-prime orders 4 and 6 keep the plain mod-q rule
    task automatic test_composite_orders();
        write_symbols(4'd5);
        send_line(6'd0);
        send_line(6'd20);
        send_line(6'd21);
        write_symbols(4'd7);
        send_line(6'd0);
        send_line(6'd42);
        drain_results();
    endtask

    // Orders below 1 or above the maximum reject every request
    task automatic test_invalid_orders();
        write_symbols(4'd0);
        send_line(6'd0);
        write_symbols(4'd1);
        send_line(6'd0);
        write_symbols(4'd9);
        send_line(6'd5);
        write_symbols(4'd15);
        send_line(6'd63);
        drain_results();
    endtask

    // Sweep every order, then random settings, each with random bursts of requests
    task automatic test_random_traffic();
        int remaining;
        int burst;
        logic pause_done;
        for (int phase = 0; phase < 12; phase++)
        begin
            if (phase < 7)
            begin
                write_symbols(SW'(8 - phase));
            end
            else
            begin
                write_symbols(SW'($urandom_range(0, 15)));
            end
            sink_free <= ($urandom_range(0, 3) == 0);
            remaining = 30;
            pause_done = 1'b0;
            while (remaining > 0)
            begin
                burst = $urandom_range(1, 8);
                for (int k = 0; k < burst && remaining > 0; k++)
                begin
                    send_line(pick_line());
                    remaining--;
                end
                // Halfway through, sometimes hold off until the block has caught up
                if (!pause_done && remaining < 15 && $urandom_range(0, 2) == 0)
                begin
                    drain_results();
                    pause_done = 1'b1;
                end
                else if ($urandom_range(0, 3) != 0)
                begin
                    hold_requests($urandom_range(1, 12));
                end
            end
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        fail_count = 0;
        plane_spc = ppis_pkg::SPC_RESET;
        sink_free <= 1'b1;
        rst_n <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.symbols_per_card <= '0;
        req_bus.valid <= 1'b0;
        req_bus.line_index <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_order();
        test_smallest_plane();
        test_composite_orders();
        test_invalid_orders();
        test_random_traffic();

        // Everything owed has arrived; give the block a little longer to misbehave
        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hang guard, well beyond the slowest legal run
    initial
    begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
